// ===== hw/rtl/vscr_pkg.sv =====
// Shared types, constants and the CORDIC angle table of the vertex set rotation unit.
package vscr_pkg;

	localparam int MAX_VERTICES_DEF = 64;
	localparam int COORD_BITS_DEF   = 32;

	localparam int OUT_BITS     = 32;
	localparam int IDX_BITS     = 6;
	localparam int ANGLE_BITS   = 16;
	localparam int DIVISOR_BITS = 7;

	localparam int CORDIC_STEPS      = 30;
	localparam int CORDIC_STEP_BITS  = 5;
	localparam int CORDIC_GAIN       = 652032874;
	localparam int TRIG_BITS         = 32;
	localparam int PHASE_BITS        = 33;
	localparam int ATAN_BITS         = 32;

	localparam int ANGLE_FULL    = 23040;
	localparam int ANGLE_HALF    = 11520;
	localparam int ANGLE_QUARTER = 5760;

	// The phase of the reduced angle is angle * 2^23 / 45. Multiplying the magnitude by the
	// rounded-up reciprocal 2^42 / 45 and dropping 19 bits gives the truncated quotient
	// exactly for every magnitude up to a quarter turn.
	localparam int PHASE_MAG_BITS    = 13;
	localparam int PHASE_RECIP_BITS  = 37;
	localparam int PHASE_RECIP_SHIFT = 19;
	localparam logic [PHASE_RECIP_BITS-1:0] PHASE_RECIP = 37'd97734366914;

	localparam int MUL_SPLIT   = 16;
	localparam int ROUND_SHIFT = 30;

	localparam logic [1:0] KIND_CLEAR        = 2'd0;
	localparam logic [1:0] KIND_APPEND       = 2'd1;
	localparam logic [1:0] KIND_ROT_CENTROID = 2'd2;
	localparam logic [1:0] KIND_ROT_KEPT     = 2'd3;

	localparam logic [1:0] AXIS_X    = 2'd0;
	localparam logic [1:0] AXIS_Y    = 2'd1;
	localparam logic [1:0] AXIS_Z    = 2'd2;
	localparam logic [1:0] AXIS_NONE = 2'd3;

	localparam logic [1:0] STATUS_ROTATED = 2'd0;
	localparam logic [1:0] STATUS_FULL    = 2'd1;
	localparam logic [1:0] STATUS_EMPTY   = 2'd2;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] turn_angle;
		logic [1:0]         turn_axis;
	} req_item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic [5:0]         vertex_index;
		logic               last_flag;
		logic [1:0]         status;
	} res_item_t;

	// Arctangent of 2^-i in units of 2^-32 turn.
	function automatic logic [ATAN_BITS-1:0] atan_turn(input logic [CORDIC_STEP_BITS-1:0] i);
		logic [ATAN_BITS-1:0] v;
		case (i)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2F9;
			5'd15: v = 32'h0000517C;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A2F;
			5'd19: v = 32'h00000517;
			5'd20: v = 32'h0000028B;
			5'd21: v = 32'h00000145;
			5'd22: v = 32'h000000A2;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000028;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000002;
			5'd29: v = 32'h00000001;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== hw/rtl/vscr_stream_if.sv =====
// Valid/ready stream interface used for the request and result channels.
interface vscr_stream_if #(parameter type item_t = logic);
	logic  valid;
	logic  ready;
	item_t item;

	modport source(output valid, output item, input ready);
	modport sink(input valid, input item, output ready);
endinterface

// ===== hw/rtl/vscr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module vscr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/vscr_div.sv =====
// Restoring divider of a signed dividend by a small positive divisor, one bit per cycle.
module vscr_div #(
	parameter int DW = 39
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [DW-1:0]                 dividend,
	input  logic [vscr_pkg::DIVISOR_BITS-1:0]    divisor,
	output logic signed [DW-1:0]                 quotient,
	output logic                                 done
);
	localparam int VW = vscr_pkg::DIVISOR_BITS;
	localparam int CNTW = $clog2(DW + 1);

	logic [DW-1:0]   mag_q;
	logic [VW:0]     rem_q;
	logic [VW-1:0]   dvs_q;
	logic [CNTW-1:0] cnt_q;
	logic            neg_q;
	logic            busy_q;
	logic [VW:0]     rem_sh;
	logic            qbit;
	logic [VW:0]     rem_nx;

	always_comb begin
		rem_sh = {rem_q[VW-1:0], mag_q[DW-1]};
		qbit   = (rem_sh >= {1'b0, dvs_q});
		rem_nx = qbit ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNTW'(DW - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DW-1];
			mag_q <= dividend[DW-1] ? (-dividend) : dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			mag_q <= {mag_q[DW-2:0], qbit};
			if (cnt_q == CNTW'(DW - 1)) begin
				quotient <= neg_q ? -$signed({mag_q[DW-2:0], qbit})
				                  : $signed({mag_q[DW-2:0], qbit});
			end
		end
	end
endmodule

// ===== hw/rtl/vscr_cordic.sv =====
// Iterative rotation-mode CORDIC giving sine and cosine in Q1.30, one step per cycle.
module vscr_cordic (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic signed [vscr_pkg::PHASE_BITS-1:0] phase,
	input  logic                                   negate,
	output logic signed [vscr_pkg::TRIG_BITS-1:0]  cos_val,
	output logic signed [vscr_pkg::TRIG_BITS-1:0]  sin_val,
	output logic                                   done
);
	localparam int XW = vscr_pkg::TRIG_BITS + 2;
	localparam int ZW = vscr_pkg::PHASE_BITS;
	localparam int SB = vscr_pkg::CORDIC_STEP_BITS;

	logic signed [XW-1:0] x_q, y_q, xs, ys, x_nx, y_nx;
	logic signed [ZW-1:0] z_q, z_nx, at;
	logic [SB-1:0]        i_q;
	logic                 busy_q;
	logic                 neg_q;

	always_comb begin
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
		at = $signed(ZW'(vscr_pkg::atan_turn(i_q)));
		if (z_q >= 0) begin
			x_nx = x_q - ys;
			y_nx = y_q + xs;
			z_nx = z_q - at;
		end else begin
			x_nx = x_q + ys;
			y_nx = y_q - xs;
			z_nx = z_q + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			i_q    <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				if (i_q == SB'(vscr_pkg::CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				i_q <= i_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= XW'(vscr_pkg::CORDIC_GAIN);
			y_q   <= '0;
			z_q   <= phase;
			neg_q <= negate;
		end else if (busy_q) begin
			x_q <= x_nx;
			y_q <= y_nx;
			z_q <= z_nx;
			if (i_q == SB'(vscr_pkg::CORDIC_STEPS - 1)) begin
				cos_val <= vscr_pkg::TRIG_BITS'(neg_q ? -x_nx : x_nx);
				sin_val <= vscr_pkg::TRIG_BITS'(neg_q ? -y_nx : y_nx);
			end
		end
	end
endmodule

// ===== hw/rtl/vertex_set_centroid_rotation_unit.sv =====
// Top level of the vertex set rotation unit: sequencer, vertex memory and arithmetic datapath.
//
// The unit keeps up to MAX_VERTICES vertices of COORD_BITS-bit Q16.16 coordinates in one
// synchronous RAM (x, y and z side by side in one word) plus a kept center point. A clear
// request empties the store and an append request writes one vertex; an append into a full
// store and a rotate on an empty store each give one status result. A rotate request first
// turns the reduced angle into a CORDIC phase (a multiply by a reciprocal of 45) and runs the
// 30-step CORDIC, then, when it rotates about a new centroid, sums the store and runs the three
// truncating bit-serial divides by the vertex count, where DW = COORD_BITS + 7. Each vertex
// then goes through one RAM read, four products each built from two 16-bit-split partial
// products on one shared multiplier and rounded (none for AXIS_NONE), the write-back and
// the hand-off to the result register. The result register decouples the two sides: the unit
// keeps working while a result waits, and accepts the next request as soon as the last
// result of the previous one has been loaded.
module vertex_set_centroid_rotation_unit #(
	parameter int MAX_VERTICES = vscr_pkg::MAX_VERTICES_DEF,
	parameter int COORD_BITS   = vscr_pkg::COORD_BITS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	vscr_stream_if.sink   request,
	vscr_stream_if.source result
);
	localparam int CB = COORD_BITS;
	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int DB = CB + 1;
	localparam int SW = CB + 7;
	localparam int PW = CB + 33;
	localparam int XW = ((CB > 32) ? CB : 32) + 4;
	localparam int DW = SW;
	localparam int TB = vscr_pkg::TRIG_BITS;
	localparam int SP = vscr_pkg::MUL_SPLIT;
	localparam int OB = vscr_pkg::OUT_BITS;
	localparam int MB = vscr_pkg::PHASE_MAG_BITS;
	localparam int QW = vscr_pkg::PHASE_MAG_BITS + vscr_pkg::PHASE_RECIP_BITS;
	localparam int HB = vscr_pkg::PHASE_BITS;

	localparam logic signed [17:0] A_FULL    = 18'(vscr_pkg::ANGLE_FULL);
	localparam logic signed [17:0] A_HALF    = 18'(vscr_pkg::ANGLE_HALF);
	localparam logic signed [17:0] A_QUARTER = 18'(vscr_pkg::ANGLE_QUARTER);
	localparam logic signed [PW-1:0] RND_HALF = PW'(1) <<< (vscr_pkg::ROUND_SHIFT - 1);

	typedef enum logic [11:0] {
		S_IDLE = 12'b0000_0000_0001,
		S_ANG  = 12'b0000_0000_0010,
		S_CORD = 12'b0000_0000_0100,
		S_SUM  = 12'b0000_0000_1000,
		S_CEN  = 12'b0000_0001_0000,
		S_RD   = 12'b0000_0010_0000,
		S_LD   = 12'b0000_0100_0000,
		S_MUL  = 12'b0000_1000_0000,
		S_ACC  = 12'b0001_0000_0000,
		S_RND  = 12'b0010_0000_0000,
		S_FIN  = 12'b0100_0000_0000,
		S_PUT  = 12'b1000_0000_0000
	} state_t;

	// Saturate a wide signed value to the stored coordinate width.
	function automatic logic signed [CB-1:0] sat_cb(input logic signed [XW-1:0] v);
		logic [XW-CB:0] up;
		logic signed [CB-1:0] r;
		up = v[XW-1:CB-1];
		if (up == '0 || up == '1) begin
			r = v[CB-1:0];
		end else if (v[XW-1]) begin
			r = {1'b1, {(CB-1){1'b0}}};
		end else begin
			r = {1'b0, {(CB-1){1'b1}}};
		end
		return r;
	endfunction

	// Saturate a stored coordinate to the 32-bit result field.
	function automatic logic signed [OB-1:0] sat_out(input logic signed [CB-1:0] v);
		logic signed [XW-1:0] w;
		logic [XW-OB:0] up;
		logic signed [OB-1:0] r;
		w  = XW'(v);
		up = w[XW-1:OB-1];
		if (up == '0 || up == '1) begin
			r = w[OB-1:0];
		end else if (w[XW-1]) begin
			r = {1'b1, {(OB-1){1'b0}}};
		end else begin
			r = {1'b0, {(OB-1){1'b1}}};
		end
		return r;
	endfunction

	state_t state_q;

	logic [1:0]  kind_q, axis_q, st_q, sel_q;
	logic [CW-1:0] cnt_q, ra_q;
	logic [AW-1:0] vi_q;
	logic        rdv_s1;
	logic        div_start_q, cor_start_q, neg_q;
	logic        term_lo_q;
	logic [1:0]  term_q;

	logic signed [CB-1:0] cen_x_q, cen_y_q, cen_z_q;
	logic signed [CB-1:0] v_x_q, v_y_q, v_z_q;
	logic signed [CB-1:0] nv_x_q, nv_y_q, nv_z_q;
	logic signed [SW-1:0] sum_x_q, sum_y_q, sum_z_q;
	logic signed [DB-1:0] d1_q, d2_q;
	logic signed [PW-1:0] prod_q, acc_q;
	logic signed [XW-1:0] res1_q, res2_q;
	logic [MB-1:0]        ang_mag_q;
	logic                 ang_sgn_q;
	logic signed [HB-1:0] phase_q;

	logic                 out_valid_q;
	vscr_pkg::res_item_t  out_q;

	// Angle reduction into [-90, 90] degrees with a negate flag.
	logic signed [17:0] ang_a, ang_r0, ang_r1, ang_r2;
	logic               ang_neg;

	always_comb begin
		ang_a = 18'(request.item.turn_angle);
		if (ang_a >= A_FULL) begin
			ang_r0 = ang_a - A_FULL;
		end else if (ang_a <= -A_FULL) begin
			ang_r0 = ang_a + A_FULL;
		end else begin
			ang_r0 = ang_a;
		end
		if (ang_r0 > A_HALF) begin
			ang_r1 = ang_r0 - A_FULL;
		end else if (ang_r0 <= -A_HALF) begin
			ang_r1 = ang_r0 + A_FULL;
		end else begin
			ang_r1 = ang_r0;
		end
		ang_neg = 1'b0;
		if (ang_r1 > A_QUARTER) begin
			ang_r2  = ang_r1 - A_HALF;
			ang_neg = 1'b1;
		end else if (ang_r1 < -A_QUARTER) begin
			ang_r2  = ang_r1 + A_HALF;
			ang_neg = 1'b1;
		end else begin
			ang_r2 = ang_r1;
		end
	end

	// CORDIC phase of the reduced angle: the magnitude times 2^23 / 45, truncated, then the
	// sign put back, so the quotient truncates toward zero.
	logic [QW-1:0] phase_prod;
	logic [HB-1:0] phase_mag;

	always_comb begin
		phase_prod = QW'(ang_mag_q) * QW'(vscr_pkg::PHASE_RECIP);
		phase_mag  = HB'(phase_prod >> vscr_pkg::PHASE_RECIP_SHIFT);
	end

	// Vertex memory: one word holds x, y and z.
	logic            ram_we;
	logic [AW-1:0]   ram_waddr, ram_raddr;
	logic [3*CB-1:0] ram_wdata, ram_rdata;
	logic signed [CB-1:0] rd_x, rd_y, rd_z;
	logic signed [CB-1:0] in_x, in_y, in_z;

	assign rd_x = ram_rdata[3*CB-1:2*CB];
	assign rd_y = ram_rdata[2*CB-1:CB];
	assign rd_z = ram_rdata[CB-1:0];
	assign in_x = sat_cb(XW'(request.item.pos_x));
	assign in_y = sat_cb(XW'(request.item.pos_y));
	assign in_z = sat_cb(XW'(request.item.pos_z));

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = vi_q;
		ram_wdata = {nv_x_q, nv_y_q, nv_z_q};
		if (state_q == S_IDLE) begin
			ram_we    = request.valid && request.item.kind == vscr_pkg::KIND_APPEND
			            && cnt_q < CW'(MAX_VERTICES);
			ram_waddr = cnt_q[AW-1:0];
			ram_wdata = {in_x, in_y, in_z};
		end else if (state_q == S_PUT && st_q == vscr_pkg::STATUS_ROTATED) begin
			ram_we = 1'b1;
		end
		ram_raddr = (state_q == S_SUM) ? ra_q[AW-1:0] : vi_q;
	end

	vscr_ram #(.WIDTH(3*CB), .DEPTH(MAX_VERTICES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Divider for the three centroid coordinates, one after another.
	logic signed [DW-1:0] div_dividend, div_quot;
	logic [vscr_pkg::DIVISOR_BITS-1:0] div_divisor;
	logic div_done;

	always_comb begin
		div_divisor = vscr_pkg::DIVISOR_BITS'(cnt_q);
		case (sel_q)
			2'd0:    div_dividend = DW'(sum_x_q);
			2'd1:    div_dividend = DW'(sum_y_q);
			default: div_dividend = DW'(sum_z_q);
		endcase
	end

	vscr_div #(.DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quot),
		.done     (div_done)
	);

	logic signed [TB-1:0] cos_v, sin_v;
	logic cor_done;

	vscr_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cor_start_q),
		.phase   (phase_q),
		.negate  (neg_q),
		.cos_val (cos_v),
		.sin_val (sin_v),
		.done    (cor_done)
	);

	// Multiplier operands: terms are c*d1, s*d2, s*d1, c*d2, each in two halves.
	logic signed [DB-1:0] mul_d;
	logic signed [TB-1:0] mul_c;
	logic signed [PW-1:0] mul_p;
	logic signed [XW-1:0] rnd_v;

	always_comb begin
		mul_d = (term_q == 2'd0 || term_q == 2'd2) ? d1_q : d2_q;
		mul_c = (term_q == 2'd0 || term_q == 2'd3) ? cos_v : sin_v;
		if (term_lo_q) begin
			mul_p = PW'($signed({1'b0, mul_d[SP-1:0]}) * mul_c);
		end else begin
			mul_p = PW'($signed(mul_d[DB-1:SP]) * mul_c);
		end
		rnd_v = XW'((acc_q + RND_HALF) >>> vscr_pkg::ROUND_SHIFT);
	end

	// Rotated pair plus center, by axis.
	logic signed [CB-1:0] cen_p1, cen_p2, rot1, rot2;

	always_comb begin
		case (axis_q)
			vscr_pkg::AXIS_X: begin
				cen_p1 = cen_y_q;
				cen_p2 = cen_z_q;
			end
			vscr_pkg::AXIS_Y: begin
				cen_p1 = cen_x_q;
				cen_p2 = cen_z_q;
			end
			default: begin
				cen_p1 = cen_x_q;
				cen_p2 = cen_y_q;
			end
		endcase
		rot1 = sat_cb(res1_q + XW'(cen_p1));
		rot2 = sat_cb(res2_q + XW'(cen_p2));
	end

	logic out_load, out_free, is_last;

	assign out_free = !out_valid_q || result.ready;
	assign out_load = (state_q == S_PUT) && out_free;
	assign is_last  = (st_q != vscr_pkg::STATUS_ROTATED) || (vi_q == AW'(cnt_q - 1'b1));

	assign request.ready = (state_q == S_IDLE);
	assign result.valid  = out_valid_q;
	assign result.item   = out_q;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			cen_x_q     <= '0;
			cen_y_q     <= '0;
			cen_z_q     <= '0;
			out_valid_q <= 1'b0;
			div_start_q <= 1'b0;
			cor_start_q <= 1'b0;
			rdv_s1      <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			cor_start_q <= 1'b0;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (request.valid) begin
						case (request.item.kind)
							vscr_pkg::KIND_CLEAR: cnt_q <= '0;
							vscr_pkg::KIND_APPEND: begin
								if (cnt_q >= CW'(MAX_VERTICES)) begin
									state_q <= S_PUT;
								end else begin
									cnt_q <= cnt_q + 1'b1;
								end
							end
							default: begin
								if (cnt_q == '0) begin
									state_q <= S_PUT;
								end else begin
									state_q <= S_ANG;
								end
							end
						endcase
					end
				end
				S_ANG: begin
					cor_start_q <= 1'b1;
					state_q     <= S_CORD;
				end
				S_CORD: begin
					if (cor_done) begin
						rdv_s1  <= 1'b0;
						state_q <= (kind_q == vscr_pkg::KIND_ROT_CENTROID) ? S_SUM : S_RD;
					end
				end
				S_SUM: begin
					rdv_s1 <= (ra_q < cnt_q);
					if (!(ra_q < cnt_q) && !rdv_s1) begin
						div_start_q <= 1'b1;
						state_q     <= S_CEN;
					end
				end
				S_CEN: begin
					if (div_done) begin
						case (sel_q)
							2'd0:    cen_x_q <= div_quot[CB-1:0];
							2'd1:    cen_y_q <= div_quot[CB-1:0];
							default: cen_z_q <= div_quot[CB-1:0];
						endcase
						if (sel_q == 2'd2) begin
							state_q <= S_RD;
						end else begin
							div_start_q <= 1'b1;
						end
					end
				end
				S_RD:  state_q <= S_LD;
				S_LD:  state_q <= (axis_q == vscr_pkg::AXIS_NONE) ? S_FIN : S_MUL;
				S_MUL: state_q <= S_ACC;
				S_ACC: state_q <= term_lo_q ? S_MUL : S_RND;
				S_RND: state_q <= (term_q == 2'd3) ? S_FIN : S_MUL;
				S_FIN: state_q <= S_PUT;
				S_PUT: begin
					if (out_free) begin
						state_q <= is_last ? S_IDLE : S_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				kind_q    <= request.item.kind;
				axis_q    <= request.item.turn_axis;
				neg_q     <= ang_neg;
				ang_sgn_q <= ang_r2[17];
				ang_mag_q <= MB'(ang_r2[17] ? -ang_r2 : ang_r2);
				vi_q      <= '0;
				ra_q      <= '0;
				sel_q     <= '0;
				sum_x_q   <= '0;
				sum_y_q   <= '0;
				sum_z_q   <= '0;
				nv_x_q    <= '0;
				nv_y_q    <= '0;
				nv_z_q    <= '0;
				st_q      <= (request.item.kind == vscr_pkg::KIND_APPEND)
				             ? vscr_pkg::STATUS_FULL
				             : ((cnt_q == '0) ? vscr_pkg::STATUS_EMPTY : vscr_pkg::STATUS_ROTATED);
			end
			S_ANG: begin
				phase_q <= ang_sgn_q ? -$signed(phase_mag) : $signed(phase_mag);
			end
			S_SUM: begin
				if (ra_q < cnt_q) begin
					ra_q <= ra_q + 1'b1;
				end
				if (rdv_s1) begin
					sum_x_q <= sum_x_q + SW'(rd_x);
					sum_y_q <= sum_y_q + SW'(rd_y);
					sum_z_q <= sum_z_q + SW'(rd_z);
				end
			end
			S_CEN: begin
				if (div_done) begin
					sel_q <= sel_q + 1'b1;
				end
			end
			S_LD: begin
				v_x_q     <= rd_x;
				v_y_q     <= rd_y;
				v_z_q     <= rd_z;
				term_q    <= '0;
				term_lo_q <= 1'b1;
				case (axis_q)
					vscr_pkg::AXIS_X: begin
						d1_q <= DB'(rd_y) - DB'(cen_y_q);
						d2_q <= DB'(rd_z) - DB'(cen_z_q);
					end
					vscr_pkg::AXIS_Y: begin
						d1_q <= DB'(rd_x) - DB'(cen_x_q);
						d2_q <= DB'(rd_z) - DB'(cen_z_q);
					end
					default: begin
						d1_q <= DB'(rd_x) - DB'(cen_x_q);
						d2_q <= DB'(rd_y) - DB'(cen_y_q);
					end
				endcase
			end
			S_MUL: prod_q <= mul_p;
			S_ACC: begin
				if (term_lo_q) begin
					acc_q <= prod_q;
				end else begin
					acc_q <= acc_q + (prod_q <<< SP);
				end
				term_lo_q <= !term_lo_q;
			end
			S_RND: begin
				case (term_q)
					2'd0:    res1_q <= rnd_v;
					2'd1:    res1_q <= res1_q - rnd_v;
					2'd2:    res2_q <= rnd_v;
					default: res2_q <= res2_q + rnd_v;
				endcase
				term_q <= term_q + 1'b1;
			end
			S_FIN: begin
				nv_x_q <= v_x_q;
				nv_y_q <= v_y_q;
				nv_z_q <= v_z_q;
				case (axis_q)
					vscr_pkg::AXIS_X: begin
						nv_y_q <= rot1;
						nv_z_q <= rot2;
					end
					vscr_pkg::AXIS_Y: begin
						nv_x_q <= rot1;
						nv_z_q <= rot2;
					end
					vscr_pkg::AXIS_Z: begin
						nv_x_q <= rot1;
						nv_y_q <= rot2;
					end
					default: begin
					end
				endcase
			end
			S_PUT: begin
				if (out_free && !is_last) begin
					vi_q <= vi_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_q.out_x        <= sat_out(nv_x_q);
			out_q.out_y        <= sat_out(nv_y_q);
			out_q.out_z        <= sat_out(nv_z_q);
			out_q.vertex_index <= vscr_pkg::IDX_BITS'(vi_q);
			out_q.last_flag    <= is_last;
			out_q.status       <= st_q;
		end
	end
endmodule

// ===== hw/rtl/vscr_checker.sv =====
// Port-level checker for the vertex set rotation unit, bound to the top level.
module vscr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic       res_last,
	input logic [1:0] res_status,
	input logic [5:0] res_index
);
	// Status results stand alone: they close their request and carry index zero.
	a_status_alone: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status != vscr_pkg::STATUS_ROTATED |-> res_last && res_index == 6'd0)
		else $error("status result without last flag or with nonzero index");

	// While a rotate is still emitting, no new request is taken.
	a_busy_mid_item: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_last |-> !req_ready)
		else $error("request ready while a rotate is still emitting");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");
endmodule

bind vertex_set_centroid_rotation_unit vscr_checker u_vscr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_ready  (request.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_last   (result.item.last_flag),
	.res_status (result.item.status),
	.res_index  (result.item.vertex_index)
);

// ===== bench/tb_vscr_checker.sv =====
// Checker for the vertex set rotation unit: watches both channels, predicts results, compares.
`timescale 1ns / 1ps
module tb_vscr_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input vscr_pkg::req_item_t req_item,
	input logic res_valid,
	input logic res_ready,
	input vscr_pkg::res_item_t res_item,
	output int fail_count,
	output int pending_results
);
	import vscr_pkg::*;

	localparam int NVERT = MAX_VERTICES_DEF;

	longint store_x[NVERT];
	longint store_y[NVERT];
	longint store_z[NVERT];
	int     stored_count;
	longint ctr_x, ctr_y, ctr_z;
	res_item_t rotated_results[$];

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Product of a coordinate difference and a Q1.30 factor, rounded, halves upward.
	function automatic longint scale_q30(longint d, longint c);
		logic signed [127:0] p;
		p = (128'(signed'(d)) * 128'(signed'(c))) + 128'sd536870912;
		return longint'(p >>> 30);
	endfunction

	task automatic trig_of(input longint ang, output longint s, output longint c);
		longint r, x, y, z, xs, ys;
		bit flip;
		r = ang % 23040;
		flip = 0;
		if (r > 11520) r -= 23040;
		if (r <= -11520) r += 23040;
		if (r > 5760) begin
			r -= 11520;
			flip = 1;
		end else if (r < -5760) begin
			r += 11520;
			flip = 1;
		end
		z = (r * 67108864) / 360;
		x = CORDIC_GAIN;
		y = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys;
				y += xs;
				z -= longint'(atan_turn(5'(i)));
			end else begin
				x += ys;
				y -= xs;
				z += longint'(atan_turn(5'(i)));
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	function automatic res_item_t status_result(logic [1:0] st);
		res_item_t r;
		r = '0;
		r.last_flag = 1'b1;
		r.status = st;
		return r;
	endfunction

	task automatic apply_request(input req_item_t q);
		longint s, c, sx, sy, sz, dx, dy, dz, x, y, z;
		res_item_t r;
		case (q.kind)
			KIND_CLEAR: stored_count = 0;
			KIND_APPEND: begin
				if (stored_count >= NVERT) rotated_results.push_back(status_result(STATUS_FULL));
				else begin
					store_x[stored_count] = longint'(q.pos_x);
					store_y[stored_count] = longint'(q.pos_y);
					store_z[stored_count] = longint'(q.pos_z);
					stored_count++;
				end
			end
			default: begin
				if (stored_count == 0) rotated_results.push_back(status_result(STATUS_EMPTY));
				else begin
					if (q.kind == KIND_ROT_CENTROID) begin
						sx = 0;
						sy = 0;
						sz = 0;
						for (int i = 0; i < stored_count; i++) begin
							sx += store_x[i];
							sy += store_y[i];
							sz += store_z[i];
						end
						ctr_x = sx / stored_count;
						ctr_y = sy / stored_count;
						ctr_z = sz / stored_count;
					end
					trig_of(longint'(q.turn_angle), s, c);
					for (int i = 0; i < stored_count; i++) begin
						x = store_x[i];
						y = store_y[i];
						z = store_z[i];
						dx = x - ctr_x;
						dy = y - ctr_y;
						dz = z - ctr_z;
						case (q.turn_axis)
							AXIS_Z: begin
								x = scale_q30(dx, c) - scale_q30(dy, s) + ctr_x;
								y = scale_q30(dx, s) + scale_q30(dy, c) + ctr_y;
							end
							AXIS_Y: begin
								x = scale_q30(dx, c) - scale_q30(dz, s) + ctr_x;
								z = scale_q30(dx, s) + scale_q30(dz, c) + ctr_z;
							end
							AXIS_X: begin
								y = scale_q30(dy, c) - scale_q30(dz, s) + ctr_y;
								z = scale_q30(dy, s) + scale_q30(dz, c) + ctr_z;
							end
							default: ;
						endcase
						store_x[i] = clamp32(x);
						store_y[i] = clamp32(y);
						store_z[i] = clamp32(z);
						r.out_x = 32'(store_x[i]);
						r.out_y = 32'(store_y[i]);
						r.out_z = 32'(store_z[i]);
						r.vertex_index = 6'(i);
						r.last_flag = (i + 1 == stored_count);
						r.status = STATUS_ROTATED;
						rotated_results.push_back(r);
					end
				end
			end
		endcase
	endtask

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	task automatic compare_result(input res_item_t g);
		res_item_t w;
		if (rotated_results.size() == 0) begin
			report("unexpected result, index", g.vertex_index, -1);
			return;
		end
		w = rotated_results.pop_front();
		if (g.out_x !== w.out_x) report("out_x", g.out_x, w.out_x);
		if (g.out_y !== w.out_y) report("out_y", g.out_y, w.out_y);
		if (g.out_z !== w.out_z) report("out_z", g.out_z, w.out_z);
		if (g.vertex_index !== w.vertex_index) report("vertex_index", g.vertex_index, w.vertex_index);
		if (g.last_flag !== w.last_flag) report("last_flag", g.last_flag, w.last_flag);
		if (g.status !== w.status) report("status", g.status, w.status);
	endtask

	initial begin
		fail_count = 0;
		stored_count = 0;
		ctr_x = 0;
		ctr_y = 0;
		ctr_z = 0;
	end

	// Results are checked before the request of the same edge is applied; a request is only
	// accepted once the previous one's last result has been loaded, so the order is safe.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && res_ready) compare_result(res_item);
			if (req_valid && req_ready) apply_request(req_item);
		end
		pending_results <= rotated_results.size();
	end
endmodule

// ===== bench/tb_vertex_set_centroid_rotation_unit.sv =====
// Testbench top for the vertex set rotation unit: stimulus, result stalls and the verdict.
`timescale 1ns / 1ps
module tb_vertex_set_centroid_rotation_unit;
	import vscr_pkg::*;

	localparam longint CYCLE_LIMIT = 20000000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending_results;
	longint cycle_count;
	bit   hold_results;
	int   drawn;

	vscr_stream_if #(.item_t(req_item_t)) request_ch();
	vscr_stream_if #(.item_t(res_item_t)) result_ch();

	vertex_set_centroid_rotation_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.request(request_ch.sink),
		.result(result_ch.source)
	);

	tb_vscr_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(request_ch.valid),
		.req_ready(request_ch.ready),
		.req_item(request_ch.item),
		.res_valid(result_ch.valid),
		.res_ready(result_ch.ready),
		.res_item(result_ch.item),
		.fail_count(fail_count),
		.pending_results(pending_results)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Idle gaps: mostly short, occasionally long.
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 40) return 0;
		if (p < 90) return $urandom_range(1, 4);
		return $urandom_range(10, 80);
	endfunction

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'($urandom);
			default: return 32'(signed'($urandom_range(0, 1 << 24)) - (1 << 23));
		endcase
	endfunction

	function automatic req_item_t make_req(logic [1:0] k, logic signed [15:0] ang, logic [1:0] ax);
		req_item_t q;
		q.kind = k;
		q.pos_x = rand_coord();
		q.pos_y = rand_coord();
		q.pos_z = rand_coord();
		q.turn_angle = ang;
		q.turn_axis = ax;
		return q;
	endfunction

	function automatic logic signed [15:0] rand_angle();
		if ($urandom_range(0, 9) == 0) return 16'($urandom);
		return 16'(signed'($urandom_range(0, 46080)) - 23040);
	endfunction

	// Drives one request, after a random gap unless no_gap is set, and waits for its acceptance.
	task automatic send(input req_item_t q, input bit no_gap);
		int g;
		g = no_gap ? 0 : gap_len();
		if (g > 0) begin
			request_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		request_ch.valid <= 1'b1;
		request_ch.item <= q;
		@(posedge clk);
		while (!request_ch.ready) @(posedge clk);
		drawn++;
	endtask

	// Result side: random stalls, or a long forced hold-off when asked.
	initial begin
		int g;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_results) begin
				result_ch.ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_results = 1'b0;
			end
			g = ($urandom_range(0, 3) == 0) ? 0 : gap_len();
			result_ch.ready <= (g == 0);
			@(posedge clk);
			if (g > 0) begin
				repeat (g - 1) @(posedge clk);
				result_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		req_item_t q;
		int fill;
		arst_n = 1'b0;
		hold_results = 1'b0;
		drawn = 0;
		request_ch.valid = 1'b0;
		request_ch.item = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty store rotates, then extremes, every axis and the wrap of the angle.
		send(make_req(KIND_ROT_CENTROID, 16'sd0, AXIS_Z), 0);
		send(make_req(KIND_ROT_KEPT, 16'sd5760, AXIS_X), 0);
		q = make_req(KIND_APPEND, 0, AXIS_X);
		q.pos_x = 32'sh7fffffff; q.pos_y = 32'sh80000000; q.pos_z = 32'sh7fffffff;
		send(q, 0);
		q.pos_x = 32'sh80000000; q.pos_y = 32'sh7fffffff; q.pos_z = 32'sh80000000;
		send(q, 0);
		q.pos_x = 32'sh00010000; q.pos_y = -32'sh00018000; q.pos_z = 32'sh0;
		send(q, 0);
		send(make_req(KIND_ROT_CENTROID, 16'sd5760, AXIS_Z), 0);
		send(make_req(KIND_ROT_KEPT, -16'sd23040, AXIS_Y), 0);
		send(make_req(KIND_ROT_KEPT, 16'sd23040, AXIS_X), 0);
		send(make_req(KIND_ROT_CENTROID, 16'sd11520, AXIS_NONE), 0);
		send(make_req(KIND_ROT_KEPT, -16'sd11520, AXIS_Y), 0);
		send(make_req(KIND_ROT_KEPT, 16'sh7fff, AXIS_Z), 0);
		send(make_req(KIND_ROT_KEPT, 16'sh8000, AXIS_X), 0);
		send(make_req(KIND_ROT_KEPT, 16'sd8000, AXIS_NONE), 0);
		send(make_req(KIND_CLEAR, 0, AXIS_X), 0);
		send(make_req(KIND_ROT_KEPT, 16'sd100, AXIS_X), 0);

		// Fill the store past full, with results held off so the unit backs up.
		for (int i = 0; i < 66; i++) send(make_req(KIND_APPEND, 0, AXIS_X), 1);
		hold_results = 1'b1;
		send(make_req(KIND_ROT_CENTROID, rand_angle(), 2'($urandom_range(0, 3))), 1);
		send(make_req(KIND_APPEND, 0, AXIS_X), 1);
		send(make_req(KIND_ROT_KEPT, rand_angle(), 2'($urandom_range(0, 3))), 1);
		send(make_req(KIND_CLEAR, 0, AXIS_X), 1);

		// Sender pauses until every expected result is back.
		request_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0 || result_ch.valid) @(posedge clk);

		// Random sets: clear, a handful of appends (now and then many, past full), a few rotates; sometimes noise.
		while (drawn < 500) begin
			if ($urandom_range(0, 7) == 0) begin
				send(make_req(2'($urandom), rand_angle(), 2'($urandom)), 0);
			end else begin
				send(make_req(KIND_CLEAR, 0, 2'($urandom)), 0);
				fill = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 66)
					: $urandom_range(0, 6);
				for (int i = 0; i < fill; i++) send(make_req(KIND_APPEND, 0, 2'($urandom)), 0);
				repeat ($urandom_range(1, 3))
					send(make_req(2'($urandom_range(2, 3)), rand_angle(), 2'($urandom)), 0);
			end
		end
		request_ch.valid <= 1'b0;

		@(posedge clk);
		while (pending_results != 0 || result_ch.valid) @(posedge clk);
		repeat (3000) @(posedge clk);
		if (fail_count == 0 && pending_results == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
